// File: rtl/hsfp_pkg.sv
`default_nettype none

package hsfp_pkg;

	// config register indexes
	localparam logic [1:0] CFG_HDR_FIRST  = 2'd0;
	localparam logic [1:0] CFG_HDR_SECOND = 2'd1;
	localparam logic [1:0] CFG_PAY_LEN    = 2'd2;

	localparam logic [7:0] HDR_FIRST_RST  = 8'hAA;
	localparam logic [7:0] HDR_SECOND_RST = 8'h55;
	localparam logic [4:0] PAY_LEN_RST    = 5'd16;

	typedef enum logic [2:0] {
		S_HUNT,
		S_LOAD,
		S_CHECK,
		S_EMIT_RD,
		S_EMIT_LD
	} state_t;

	typedef struct packed {
		logic accept;     // input item taken: shift prev byte
		logic clr_frame;  // header seen: clear count and sum
		logic load;       // store payload byte, count, sum
		logic idx_clr;    // restart readout index
		logic emit_good;  // push stored byte to output register
		logic emit_bad;   // push checksum-failure item
	} cmd_t;

	typedef struct packed {
		logic hdr_match;
		logic load_done;
		logic sum_match;
		logic emit_last;
		logic out_free;
	} status_t;

endpackage

`default_nettype wire

// File: rtl/hsfp_ram.sv
`default_nettype none

module hsfp_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  wire logic                                  clk,
	input  wire logic                                  we,
	input  wire logic [$clog2(DEPTH > 1 ? DEPTH : 2)-1:0] waddr,
	input  wire logic [WIDTH-1:0]                      wdata,
	input  wire logic [$clog2(DEPTH > 1 ? DEPTH : 2)-1:0] raddr,
	output logic      [WIDTH-1:0]                      rdata
);
	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule

`default_nettype wire

// File: rtl/hsfp_ctrl.sv
`default_nettype none

module hsfp_ctrl (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               in_valid,
	output logic                    in_stall,
	input  wire hsfp_pkg::status_t  sts,
	output hsfp_pkg::cmd_t          cmd
);
	hsfp_pkg::state_t state_q, state_nx;
	logic acc;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= hsfp_pkg::S_HUNT;
		end else begin
			state_q <= state_nx;
		end
	end

	// input is blocked during readout, and in CHECK until the output slot is free
	always_comb begin
		unique case (state_q)
			hsfp_pkg::S_HUNT, hsfp_pkg::S_LOAD: in_stall = 1'b0;
			hsfp_pkg::S_CHECK:                  in_stall = !sts.out_free;
			default:                            in_stall = 1'b1;
		endcase
	end

	assign acc = in_valid && !in_stall;

	always_comb begin
		state_nx = state_q;
		unique case (state_q)
			hsfp_pkg::S_HUNT: begin
				if (acc && sts.hdr_match) state_nx = hsfp_pkg::S_LOAD;
			end
			hsfp_pkg::S_LOAD: begin
				if (acc && sts.load_done) state_nx = hsfp_pkg::S_CHECK;
			end
			hsfp_pkg::S_CHECK: begin
				if (acc) state_nx = sts.sum_match ? hsfp_pkg::S_EMIT_RD : hsfp_pkg::S_HUNT;
			end
			hsfp_pkg::S_EMIT_RD: state_nx = hsfp_pkg::S_EMIT_LD;
			hsfp_pkg::S_EMIT_LD: begin
				if (sts.out_free) begin
					state_nx = sts.emit_last ? hsfp_pkg::S_HUNT : hsfp_pkg::S_EMIT_RD;
				end
			end
			default: state_nx = hsfp_pkg::S_HUNT;
		endcase
	end

	always_comb begin
		cmd = '0;
		cmd.accept = acc;
		unique case (state_q)
			hsfp_pkg::S_HUNT:    cmd.clr_frame = acc && sts.hdr_match;
			hsfp_pkg::S_LOAD:    cmd.load = acc;
			hsfp_pkg::S_CHECK: begin
				cmd.idx_clr  = acc && sts.sum_match;
				cmd.emit_bad = acc && !sts.sum_match;
			end
			hsfp_pkg::S_EMIT_LD: cmd.emit_good = sts.out_free;
			default: ;
		endcase
	end

endmodule

`default_nettype wire

// File: rtl/hsfp_dp.sv
`default_nettype none

module hsfp_dp #(
	parameter int MAX_PAYLOAD = 16
) (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire hsfp_pkg::cmd_t    cmd,
	output hsfp_pkg::status_t      sts,
	input  wire logic [7:0]        rx_byte,
	input  wire logic              cfg_we,
	input  wire logic [1:0]        cfg_index,
	input  wire logic [7:0]        cfg_data,
	output logic                   out_valid,
	input  wire logic              out_stall,
	output logic [7:0]             data_byte,
	output logic                   frame_ok,
	output logic                   last
);
	localparam int CNT_W = $clog2(MAX_PAYLOAD + 1);
	localparam int AW    = (MAX_PAYLOAD > 1) ? $clog2(MAX_PAYLOAD) : 1;
	localparam int CMP_W = (CNT_W > 5) ? CNT_W : 5;

	logic [7:0]       hdr1_q, hdr2_q, prev_q, sum_q;
	logic [4:0]       len_q;
	logic [CNT_W-1:0] cnt_q, cnt_nx, idx_q;
	logic [CMP_W-1:0] eff_len, len_ext, max_ext;
	logic [7:0]       ram_rdata;
	logic             out_valid_q;
	logic             cnt_room;

	// config registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			hdr1_q <= hsfp_pkg::HDR_FIRST_RST;
			hdr2_q <= hsfp_pkg::HDR_SECOND_RST;
			len_q  <= hsfp_pkg::PAY_LEN_RST;
		end else if (cfg_we) begin
			unique case (cfg_index)
				hsfp_pkg::CFG_HDR_FIRST:  hdr1_q <= cfg_data;
				hsfp_pkg::CFG_HDR_SECOND: hdr2_q <= cfg_data;
				hsfp_pkg::CFG_PAY_LEN:    len_q  <= cfg_data[4:0];
				default: ;
			endcase
		end
	end

	// length saturated to 1..MAX_PAYLOAD
	assign len_ext = CMP_W'(len_q);
	assign max_ext = CMP_W'(MAX_PAYLOAD);
	always_comb begin
		priority if (len_q == 5'd0) eff_len = CMP_W'(1);
		else if (len_ext > max_ext) eff_len = max_ext;
		else eff_len = len_ext;
	end

	assign cnt_room = (cnt_q < CNT_W'(MAX_PAYLOAD));
	assign cnt_nx   = cnt_room ? cnt_q + CNT_W'(1) : cnt_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			prev_q <= '0;
			cnt_q  <= '0;
			sum_q  <= '0;
			idx_q  <= '0;
		end else begin
			if (cmd.accept) prev_q <= rx_byte;
			if (cmd.clr_frame) begin
				cnt_q <= '0;
				sum_q <= '0;
			end else if (cmd.load) begin
				cnt_q <= cnt_nx;
				sum_q <= sum_q + rx_byte;
			end
			if (cmd.idx_clr) idx_q <= '0;
			else if (cmd.emit_good) idx_q <= idx_q + CNT_W'(1);
		end
	end

	hsfp_ram #(
		.WIDTH(8),
		.DEPTH(MAX_PAYLOAD)
	) u_store (
		.clk   (clk),
		.we    (cmd.load && cnt_room),
		.waddr (cnt_q[AW-1:0]),
		.wdata (rx_byte),
		.raddr (idx_q[AW-1:0]),
		.rdata (ram_rdata)
	);

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.emit_good || cmd.emit_bad) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.emit_good) begin
			data_byte <= ram_rdata;
			frame_ok  <= 1'b1;
			last      <= sts.emit_last;
		end else if (cmd.emit_bad) begin
			data_byte <= '0;
			frame_ok  <= 1'b0;
			last      <= 1'b1;
		end
	end

	assign out_valid = out_valid_q;

	assign sts.hdr_match = (prev_q == hdr1_q) && (rx_byte == hdr2_q);
	assign sts.load_done = (CMP_W'(cnt_nx) >= eff_len);
	assign sts.sum_match = (sum_q == rx_byte) && (cnt_q != '0);
	assign sts.emit_last = (idx_q + CNT_W'(1) == cnt_q);
	assign sts.out_free  = !out_valid_q || !out_stall;

endmodule

`default_nettype wire

// File: rtl/header_sum_frame_parser.sv
// Serial frame parser: two sync bytes, payload, one-byte additive checksum.
// Input channel (in_valid/in_stall/rx_byte) takes one received byte per item.
// Output channel (out_valid/out_stall) delivers data_byte, frame_ok, last.
// Config channel (cfg_valid/cfg_ready/cfg_index/cfg_data) sets header_first
// (index 0), header_second (1) and payload_length (2); cfg_ready is always high.
// Header hunting and payload loading take one byte per cycle. The checksum
// byte is taken once the output register is free; on a match the payload is
// read back from the frame store byte by byte (address state, then registered
// read data), and in_stall stays high for the whole readout. A bad checksum
// gives a single item (data_byte 0, frame_ok 0, last 1) with no readout.
// A failure item is valid the cycle after its checksum byte is taken; the
// first item of a good frame comes later, once the address state and the
// registered read data have passed and the output register is loaded.
// A stalled output holds its item; the block keeps taking header and payload
// bytes while a finished item waits, and only blocks at the next checksum
// byte or readout.
// Reset (arst_n low) returns to header hunting, clears the byte history,
// count and sum, and restores header 0xAA 0x55 and length 16. The frame store
// needs no clearing: only bytes of the current frame are read back.
`default_nettype none

module header_sum_frame_parser #(
	parameter int MAX_PAYLOAD = 16
) (
	input  wire logic       clk,
	input  wire logic       arst_n,
	// byte input
	input  wire logic       in_valid,
	output logic            in_stall,
	input  wire logic [7:0] rx_byte,
	// result output
	output logic            out_valid,
	input  wire logic       out_stall,
	output logic [7:0]      data_byte,
	output logic            frame_ok,
	output logic            last,
	// config write
	input  wire logic       cfg_valid,
	output logic            cfg_ready,
	input  wire logic [1:0] cfg_index,
	input  wire logic [7:0] cfg_data
);
	hsfp_pkg::cmd_t    cmd;
	hsfp_pkg::status_t sts;

	assign cfg_ready = 1'b1;

	hsfp_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_stall (in_stall),
		.sts      (sts),
		.cmd      (cmd)
	);

	hsfp_dp #(
		.MAX_PAYLOAD(MAX_PAYLOAD)
	) u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd       (cmd),
		.sts       (sts),
		.rx_byte   (rx_byte),
		.cfg_we    (cfg_valid && cfg_ready),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.data_byte (data_byte),
		.frame_ok  (frame_ok),
		.last      (last)
	);

endmodule

`default_nettype wire

// File: tb/header_sum_frame_parser_checker.sv
`default_nettype none

module header_sum_frame_parser_checker #(
	parameter int MAX_PAYLOAD = 16
) (
	input  wire logic       clk,
	input  wire logic       arst_n,
	input  wire logic       in_valid,
	input  wire logic       in_stall,
	input  wire logic [7:0] rx_byte,
	input  wire logic       out_valid,
	input  wire logic       out_stall,
	input  wire logic [7:0] data_byte,
	input  wire logic       frame_ok,
	input  wire logic       last,
	input  wire logic       cfg_valid,
	input  wire logic       cfg_ready,
	input  wire logic [1:0] cfg_index,
	input  wire logic [7:0] cfg_data,
	output int              fail_count,
	output int              pending_count
);

	typedef struct packed {
		logic [7:0] data;
		logic       ok;
		logic       last;
	} frame_item_t;

	frame_item_t frame_items_q[$];
	frame_item_t want;

	// shadow registers and parser state
	logic [7:0]        hdr_first, hdr_second;
	logic [4:0]        pay_len;
	hsfp_pkg::state_t  phase;
	logic [7:0]        prev_rx;
	logic [4:0]        count;
	logic [7:0]        sum;
	logic [7:0]        store [MAX_PAYLOAD];

	int mismatches = 0;
	int waiting = 0;

	assign fail_count    = mismatches;
	assign pending_count = waiting;

	task automatic report_mismatch(input string what, input int got, input int exp_v);
		if (mismatches < 50)
			$display("%0t mismatch: %s got %0h want %0h", $realtime, what, got, exp_v);
		mismatches++;
	endtask

	function automatic int frame_len();
		int n;
		n = pay_len;
		if (n == 0) n = 1;
		if (n > MAX_PAYLOAD) n = MAX_PAYLOAD;
		return n;
	endfunction

	task automatic parse_byte(input logic [7:0] b);
		int i;
		case (phase)
			hsfp_pkg::S_HUNT: begin
				if (prev_rx == hdr_first && b == hdr_second) begin
					count = '0;
					sum   = '0;
					phase = hsfp_pkg::S_LOAD;
				end
			end
			hsfp_pkg::S_LOAD: begin
				if (count < MAX_PAYLOAD) begin
					store[count] = b;
					count++;
				end
				sum = sum + b;
				if (count >= frame_len()) phase = hsfp_pkg::S_CHECK;
			end
			hsfp_pkg::S_CHECK: begin
				if (sum == b && count > 0) begin
					for (i = 0; i < count && i < MAX_PAYLOAD; i++)
						frame_items_q.push_back('{store[i], 1'b1, (i + 1 == count)});
				end else begin
					frame_items_q.push_back('{8'h00, 1'b0, 1'b1});
				end
				count = '0;
				sum   = '0;
				phase = hsfp_pkg::S_HUNT;
			end
			default: begin
				count = '0;
				sum   = '0;
				phase = hsfp_pkg::S_HUNT;
			end
		endcase
		prev_rx = b;
	endtask

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			hdr_first  = hsfp_pkg::HDR_FIRST_RST;
			hdr_second = hsfp_pkg::HDR_SECOND_RST;
			pay_len    = hsfp_pkg::PAY_LEN_RST;
			phase      = hsfp_pkg::S_HUNT;
			prev_rx    = '0;
			count      = '0;
			sum        = '0;
			frame_items_q.delete();
			waiting <= 0;
		end else begin
			// an output item can never stem from the byte taken at this same edge
			if (out_valid && !out_stall) begin
				if (frame_items_q.size() == 0) begin
					report_mismatch("unexpected item, data_byte", data_byte, 0);
				end else begin
					want = frame_items_q.pop_front();
					if (data_byte !== want.data)
						report_mismatch("data_byte", data_byte, want.data);
					if (frame_ok !== want.ok)
						report_mismatch("frame_ok", frame_ok, want.ok);
					if (last !== want.last)
						report_mismatch("last", last, want.last);
				end
			end
			// a byte taken at the same edge as a register write sees the old value
			if (in_valid && !in_stall) parse_byte(rx_byte);
			if (cfg_valid && cfg_ready) begin
				case (cfg_index)
					hsfp_pkg::CFG_HDR_FIRST:  hdr_first  = cfg_data;
					hsfp_pkg::CFG_HDR_SECOND: hdr_second = cfg_data;
					hsfp_pkg::CFG_PAY_LEN:    pay_len    = cfg_data[4:0];
					default: ;
				endcase
			end
			waiting <= frame_items_q.size();
		end
	end

endmodule

`default_nettype wire

// File: tb/header_sum_frame_parser_tb.sv
`default_nettype none

// Stimulus and verdict for the frame parser. The checker beside the block
// predicts every output item from the accepted bytes and config writes.
module header_sum_frame_parser_tb;

	localparam int         MAX_PAYLOAD = 16;
	// index 3 maps to no register; writes to it must be ignored
	localparam logic [1:0] CFG_UNUSED  = 2'd3;

	logic       clk = 1'b0;
	logic       arst_n;
	logic       in_valid;
	logic       in_stall;
	logic [7:0] rx_byte;
	logic       out_valid;
	logic       out_stall = 1'b0;
	logic [7:0] data_byte;
	logic       frame_ok;
	logic       last;
	logic       cfg_valid;
	logic       cfg_ready;
	logic [1:0] cfg_index;
	logic [7:0] cfg_data;

	int fail_count;
	int pending_count;

	// percent chance per cycle of a sender gap / receiver stall
	int idle_pct  = 0;
	int stall_pct = 0;

	// local copy of the register values, used only to build frames
	logic [7:0] hf_cur = hsfp_pkg::HDR_FIRST_RST;
	logic [7:0] hs_cur = hsfp_pkg::HDR_SECOND_RST;
	logic [4:0] len_cur = hsfp_pkg::PAY_LEN_RST;

	header_sum_frame_parser #(.MAX_PAYLOAD(MAX_PAYLOAD)) dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.rx_byte   (rx_byte),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.data_byte (data_byte),
		.frame_ok  (frame_ok),
		.last      (last),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data)
	);

	header_sum_frame_parser_checker #(.MAX_PAYLOAD(MAX_PAYLOAD)) u_checker (
		.clk           (clk),
		.arst_n        (arst_n),
		.in_valid      (in_valid),
		.in_stall      (in_stall),
		.rx_byte       (rx_byte),
		.out_valid     (out_valid),
		.out_stall     (out_stall),
		.data_byte     (data_byte),
		.frame_ok      (frame_ok),
		.last          (last),
		.cfg_valid     (cfg_valid),
		.cfg_ready     (cfg_ready),
		.cfg_index     (cfg_index),
		.cfg_data      (cfg_data),
		.fail_count    (fail_count),
		.pending_count (pending_count)
	);

	always begin
		#10 clk = 1'b1;
		#10 clk = 1'b0;
	end

	// receiver back-pressure, one decision per cycle
	always @(posedge clk) begin
		out_stall <= ($urandom_range(99) < stall_pct);
	end

	// worst case is far below this: ~500 bytes, 16-item readouts under heavy stall
	initial begin
		#5_000_000;
		$display("CHECK FAILED");
		$finish;
	end

	// Offer one byte, with random gaps first; returns once it is taken.
	// in_valid stays high into the next call unless that call opens a gap.
	task automatic push_byte(input logic [7:0] b);
		while ($urandom_range(99) < idle_pct) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid <= 1'b1;
		rx_byte  <= b;
		do @(posedge clk); while (in_stall);
	endtask

	// Sender quiet until every predicted item is out, then still quiet
	// for any byte in flight inside the block.
	task automatic drain();
		in_valid <= 1'b0;
		do @(posedge clk); while (pending_count != 0);
		repeat (8) @(posedge clk);
	endtask

	// cfg_valid is left high; the caller lowers it after its last write
	task automatic write_reg(input logic [1:0] idx, input logic [7:0] val);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= val;
		do @(posedge clk); while (!cfg_ready);
		case (idx)
			hsfp_pkg::CFG_HDR_FIRST:  hf_cur  = val;
			hsfp_pkg::CFG_HDR_SECOND: hs_cur  = val;
			hsfp_pkg::CFG_PAY_LEN:    len_cur = val[4:0];
			default: ;
		endcase
	endtask

	// Only called from idle. Upper length bits are junk the block must drop.
	task automatic configure(input logic [7:0] hf, input logic [7:0] hs,
			input logic [4:0] len, input bit poke_unused);
		write_reg(hsfp_pkg::CFG_HDR_FIRST, hf);
		write_reg(hsfp_pkg::CFG_HDR_SECOND, hs);
		write_reg(hsfp_pkg::CFG_PAY_LEN, {3'($urandom), len});
		if (poke_unused) write_reg(CFG_UNUSED, 8'($urandom));
		cfg_valid <= 1'b0;
	endtask

	function automatic int frame_len();
		int n;
		n = len_cur;
		if (n == 0) n = 1;
		if (n > MAX_PAYLOAD) n = MAX_PAYLOAD;
		return n;
	endfunction

	// header, random payload, checksum (corrupted when !good)
	task automatic send_frame(input bit good);
		logic [7:0] sum, b;
		int i;
		sum = '0;
		push_byte(hf_cur);
		push_byte(hs_cur);
		for (i = 0; i < frame_len(); i++) begin
			b = 8'($urandom);
			sum = sum + b;
			push_byte(b);
		end
		push_byte(good ? sum : sum ^ 8'($urandom_range(1, 255)));
	endtask

	// Mostly well-formed frames; some noise while hunting and some frames
	// cut short, whose tail then swallows the next header as payload.
	task automatic run_traffic(input int n_items);
		int sent, r, i, n;
		sent = 0;
		while (sent < n_items) begin
			r = $urandom_range(99);
			if (r < 10) begin
				n = $urandom_range(1, 3);
				for (i = 0; i < n; i++) push_byte(8'($urandom));
				sent += n;
			end else if (r < 18) begin
				push_byte(hf_cur);
				push_byte(hs_cur);
				n = $urandom_range(0, frame_len() - 1);
				for (i = 0; i < n; i++) push_byte(8'($urandom));
				sent += n + 2;
			end else begin
				send_frame($urandom_range(99) < 80);
				sent += frame_len() + 3;
			end
		end
	endtask

	initial begin
		int ph, sub;
		arst_n    <= 1'b0;
		in_valid  <= 1'b0;
		rx_byte   <= '0;
		cfg_valid <= 1'b0;
		cfg_index <= hsfp_pkg::CFG_HDR_FIRST;
		cfg_data  <= '0;
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// --- directed ---
		configure(hsfp_pkg::HDR_FIRST_RST, hsfp_pkg::HDR_SECOND_RST, 5'd2, 1'b0);
		// good frame, payload at both byte extremes
		push_byte(8'hAA); push_byte(8'h55); push_byte(8'h00); push_byte(8'hFF);
		push_byte(8'hFF);
		// bad checksum: single failure item
		push_byte(8'hAA); push_byte(8'h55); push_byte(8'h12); push_byte(8'h34);
		push_byte(8'h00);
		// header bytes inside the payload are plain data
		push_byte(8'hAA); push_byte(8'h55); push_byte(8'hAA); push_byte(8'h55);
		push_byte(8'hFF);
		// second header byte alone while hunting does nothing
		push_byte(8'h55); push_byte(8'h00);
		drain();

		// zero length behaves as one
		configure(hsfp_pkg::HDR_FIRST_RST, hsfp_pkg::HDR_SECOND_RST, 5'd0, 1'b0);
		push_byte(8'hAA); push_byte(8'h55); push_byte(8'h7F); push_byte(8'h7F);
		drain();

		// length shrunk mid-frame below the count already loaded:
		// the next payload byte ends loading
		configure(hsfp_pkg::HDR_FIRST_RST, hsfp_pkg::HDR_SECOND_RST, 5'd16, 1'b0);
		push_byte(8'hAA); push_byte(8'h55);
		push_byte(8'h01); push_byte(8'h02); push_byte(8'h03);
		drain();
		configure(hsfp_pkg::HDR_FIRST_RST, hsfp_pkg::HDR_SECOND_RST, 5'd2, 1'b0);
		push_byte(8'h04); push_byte(8'h0A);
		drain();

		// --- random, four idling regimes, two settings each ---
		for (ph = 0; ph < 4; ph++) begin
			for (sub = 0; sub < 2; sub++) begin
				drain();
				case (ph)
					0: begin idle_pct = 0;  stall_pct = 0;  end
					1: begin idle_pct = 68; stall_pct = 0;  end
					2: begin idle_pct = 0;  stall_pct = 68; end
					default: begin idle_pct = 28; stall_pct = 28; end
				endcase
				case (ph * 2 + sub)
					0: configure(8'h00, 8'hFF, 5'd1, 1'b0);
					1: configure(8'hFF, 8'h00, 5'd31, 1'b0);    // saturates to max
					2: configure(8'($urandom), 8'($urandom), 5'd16, 1'b0);
					3: configure(8'($urandom), 8'($urandom), 5'($urandom_range(1, 8)), 1'b1);
					7: configure(8'($urandom), 8'($urandom), 5'd0, 1'b0);
					default: configure(8'($urandom), 8'($urandom),
						5'($urandom_range(1, 10)), 1'b0);
				endcase
				run_traffic(50);
			end
		end

		drain();
		repeat (20) @(posedge clk);
		if (fail_count == 0)
			$display("CHECK OK");
		else
			$display("CHECK FAILED");
		$finish;
	end

endmodule

`default_nettype wire
